// ===== design/smhs_pkg.sv =====
// Shared types and constants for the speed mode hysteresis select unit.
package smhs_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int COUNT_W     = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_NORMAL_SPEED        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAST_SPEED          = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTER_TTC_MS        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXIT_TTC_MS         = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTER_BEARING_CDEG  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXIT_BEARING_CDEG   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTER_ATTITUDE_CDEG = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXIT_ATTITUDE_CDEG  = 3'd7;

   localparam logic [15:0] RST_NORMAL_SPEED        = 16'd0;
   localparam logic [15:0] RST_FAST_SPEED          = 16'd0;
   localparam logic [15:0] RST_ENTER_TTC_MS        = 16'd500;
   localparam logic [15:0] RST_EXIT_TTC_MS         = 16'd200;
   localparam logic [14:0] RST_ENTER_BEARING_CDEG  = 15'd2400;
   localparam logic [14:0] RST_EXIT_BEARING_CDEG   = 15'd3000;
   localparam logic [15:0] RST_ENTER_ATTITUDE_CDEG = 16'd2000;
   localparam logic [15:0] RST_EXIT_ATTITUDE_CDEG  = 16'd3000;

   localparam logic signed [15:0] MIN_SPEED_MM_S      = 16'sd500;
   localparam logic signed [15:0] ENTER_YAW_RATE_DDPS = 16'sd600;
   localparam logic signed [15:0] EXIT_YAW_RATE_DDPS  = 16'sd1000;
   localparam logic signed [17:0] HALF_TURN_CDEG      = 18'sd18000;
   localparam logic signed [17:0] FULL_TURN_CDEG      = 18'sd36000;
   localparam logic [9:0]         MS_PER_S            = 10'd1000;

   typedef struct packed {
      logic              target_seen;
      logic [15:0]       target_distance_mm;
      logic signed [15:0] target_bearing_cdeg;
      logic signed [15:0] forward_speed_mm_s;
      logic signed [15:0] yaw_rate_ddps;
      logic signed [15:0] roll_cdeg;
      logic signed [15:0] pitch_cdeg;
      logic signed [15:0] yaw_cdeg;
      logic signed [15:0] roll_goal_cdeg;
      logic signed [15:0] pitch_goal_cdeg;
      logic signed [15:0] yaw_goal_cdeg;
   } req_type;

   typedef struct packed {
      logic [15:0] speed_command;
      logic        fast_mode;
   } rsp_type;

   typedef struct packed {
      logic [15:0] normal_speed;
      logic [15:0] fast_speed;
      logic [15:0] enter_ttc_ms;
      logic [15:0] exit_ttc_ms;
      logic [14:0] enter_bearing_cdeg;
      logic [14:0] exit_bearing_cdeg;
      logic [15:0] enter_attitude_cdeg;
      logic [15:0] exit_attitude_cdeg;
   } csr_type;

   typedef struct packed {
      logic        target_seen;
      logic [25:0] range_scaled;
      logic [30:0] enter_ttc_prod;
      logic [30:0] exit_ttc_prod;
      logic        bearing_enter_ok;
      logic        bearing_exit;
      logic        yaw_rate_enter_ok;
      logic        yaw_rate_exit;
      logic [31:0] roll_sq;
      logic [31:0] pitch_sq;
      logic [31:0] yaw_sq;
      logic [31:0] enter_att_sq;
      logic [31:0] exit_att_sq;
   } metric_type;

   typedef struct packed {
      logic               mode_fast;
      logic [COUNT_W-1:0] confirm_count;
   } status_type;

endpackage

// ===== design/smhs_csr.sv =====
// Configuration register file for the speed mode selector.
module smhs_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [smhs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [smhs_pkg::CSR_DATA_W-1:0]    csr_data,
   output smhs_pkg::csr_type                  cfg
);

   smhs_pkg::csr_type cfg_ff;
   smhs_pkg::csr_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            smhs_pkg::CSR_NORMAL_SPEED:        cfg_in.normal_speed        = csr_data;
            smhs_pkg::CSR_FAST_SPEED:          cfg_in.fast_speed          = csr_data;
            smhs_pkg::CSR_ENTER_TTC_MS:        cfg_in.enter_ttc_ms        = csr_data;
            smhs_pkg::CSR_EXIT_TTC_MS:         cfg_in.exit_ttc_ms         = csr_data;
            smhs_pkg::CSR_ENTER_BEARING_CDEG:  cfg_in.enter_bearing_cdeg  = csr_data[14:0];
            smhs_pkg::CSR_EXIT_BEARING_CDEG:   cfg_in.exit_bearing_cdeg   = csr_data[14:0];
            smhs_pkg::CSR_ENTER_ATTITUDE_CDEG: cfg_in.enter_attitude_cdeg = csr_data;
            smhs_pkg::CSR_EXIT_ATTITUDE_CDEG:  cfg_in.exit_attitude_cdeg  = csr_data;
            default:                           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.normal_speed        <= smhs_pkg::RST_NORMAL_SPEED;
         cfg_ff.fast_speed          <= smhs_pkg::RST_FAST_SPEED;
         cfg_ff.enter_ttc_ms        <= smhs_pkg::RST_ENTER_TTC_MS;
         cfg_ff.exit_ttc_ms         <= smhs_pkg::RST_EXIT_TTC_MS;
         cfg_ff.enter_bearing_cdeg  <= smhs_pkg::RST_ENTER_BEARING_CDEG;
         cfg_ff.exit_bearing_cdeg   <= smhs_pkg::RST_EXIT_BEARING_CDEG;
         cfg_ff.enter_attitude_cdeg <= smhs_pkg::RST_ENTER_ATTITUDE_CDEG;
         cfg_ff.exit_attitude_cdeg  <= smhs_pkg::RST_EXIT_ATTITUDE_CDEG;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/smhs_measure.sv =====
// Product stage: scaled range, time-to-collision products, squared attitude errors.
module smhs_measure (
   input  logic                  clock,
   input  logic                  load,
   input  smhs_pkg::req_type     sample,
   input  smhs_pkg::csr_type     cfg,
   output smhs_pkg::metric_type  metric
);

   smhs_pkg::metric_type metric_ff;
   smhs_pkg::metric_type metric_in;

   logic signed [15:0] speed_clamped;
   logic [14:0]        speed_mag;
   logic signed [16:0] droll;
   logic signed [16:0] dpitch;
   logic signed [17:0] dyaw_raw;
   logic signed [17:0] dyaw;
   logic signed [33:0] roll_prod;
   logic signed [33:0] pitch_prod;
   logic signed [35:0] yaw_prod;
   logic signed [16:0] bearing_ext;

   always_comb begin
      speed_clamped = (sample.forward_speed_mm_s < smhs_pkg::MIN_SPEED_MM_S)
                      ? smhs_pkg::MIN_SPEED_MM_S : sample.forward_speed_mm_s;
      speed_mag     = speed_clamped[14:0];

      droll    = {sample.roll_cdeg[15], sample.roll_cdeg}
               - {sample.roll_goal_cdeg[15], sample.roll_goal_cdeg};
      dpitch   = {sample.pitch_cdeg[15], sample.pitch_cdeg}
               - {sample.pitch_goal_cdeg[15], sample.pitch_goal_cdeg};
      dyaw_raw = {{2{sample.yaw_cdeg[15]}}, sample.yaw_cdeg}
               - {{2{sample.yaw_goal_cdeg[15]}}, sample.yaw_goal_cdeg};
      if (dyaw_raw > smhs_pkg::HALF_TURN_CDEG) begin
         dyaw = dyaw_raw - smhs_pkg::FULL_TURN_CDEG;
      end else if (dyaw_raw < -smhs_pkg::HALF_TURN_CDEG) begin
         dyaw = dyaw_raw + smhs_pkg::FULL_TURN_CDEG;
      end else begin
         dyaw = dyaw_raw;
      end

      roll_prod  = droll * droll;
      pitch_prod = dpitch * dpitch;
      yaw_prod   = dyaw * dyaw;

      bearing_ext = {sample.target_bearing_cdeg[15], sample.target_bearing_cdeg};

      metric_in.target_seen    = sample.target_seen;
      metric_in.range_scaled   = sample.target_distance_mm * smhs_pkg::MS_PER_S;
      metric_in.enter_ttc_prod = cfg.enter_ttc_ms * speed_mag;
      metric_in.exit_ttc_prod  = cfg.exit_ttc_ms * speed_mag;
      metric_in.bearing_enter_ok =
         bearing_ext < $signed({2'b00, cfg.enter_bearing_cdeg});
      metric_in.bearing_exit =
         bearing_ext > $signed({2'b00, cfg.exit_bearing_cdeg});
      metric_in.yaw_rate_enter_ok =
         (sample.yaw_rate_ddps < smhs_pkg::ENTER_YAW_RATE_DDPS) &&
         (sample.yaw_rate_ddps > -smhs_pkg::ENTER_YAW_RATE_DDPS);
      metric_in.yaw_rate_exit =
         (sample.yaw_rate_ddps > smhs_pkg::EXIT_YAW_RATE_DDPS) ||
         (sample.yaw_rate_ddps < -smhs_pkg::EXIT_YAW_RATE_DDPS);
      metric_in.roll_sq      = roll_prod[31:0];
      metric_in.pitch_sq     = pitch_prod[31:0];
      metric_in.yaw_sq       = yaw_prod[31:0];
      metric_in.enter_att_sq = cfg.enter_attitude_cdeg * cfg.enter_attitude_cdeg;
      metric_in.exit_att_sq  = cfg.exit_attitude_cdeg * cfg.exit_attitude_cdeg;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         metric_ff <= metric_in;
      end
   end

   assign metric = metric_ff;

endmodule

// ===== design/smhs_decide.sv =====
// Decision stage: threshold tests, confirmation counter, mode and result register.
module smhs_decide #(
   parameter int CONFIRM_COUNT = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  smhs_pkg::metric_type  metric,
   input  smhs_pkg::csr_type     cfg,
   output smhs_pkg::rsp_type     rsp_data,
   output smhs_pkg::status_type  status
);

   localparam logic [smhs_pkg::COUNT_W-1:0] CONFIRM_LIMIT =
      smhs_pkg::COUNT_W'(CONFIRM_COUNT);

   logic                           mode_ff;
   logic                           mode_in;
   logic [smhs_pkg::COUNT_W-1:0]   count_ff;
   logic [smhs_pkg::COUNT_W-1:0]   count_in;
   smhs_pkg::rsp_type              rsp_ff;
   smhs_pkg::rsp_type              rsp_in;

   logic [33:0]                    sq_sum;
   logic [30:0]                    range_ext;
   logic                           enter_met;
   logic                           exit_met;
   logic                           met;
   logic [smhs_pkg::COUNT_W-1:0]   count_inc;

   always_comb begin
      sq_sum    = {2'b00, metric.roll_sq} + {2'b00, metric.pitch_sq}
                + {2'b00, metric.yaw_sq};
      range_ext = {5'd0, metric.range_scaled};
      enter_met = (range_ext > metric.enter_ttc_prod) && metric.bearing_enter_ok &&
                  metric.yaw_rate_enter_ok && (sq_sum < {2'b00, metric.enter_att_sq});
      exit_met  = (range_ext < metric.exit_ttc_prod) || metric.bearing_exit ||
                  metric.yaw_rate_exit || (sq_sum > {2'b00, metric.exit_att_sq});
      met       = mode_ff ? exit_met : enter_met;
      count_inc = count_ff + 1'b1;

      mode_in  = mode_ff;
      count_in = count_ff;
      if (advance) begin
         if (!metric.target_seen || !met) begin
            count_in = '0;
         end else if ((count_inc >= CONFIRM_LIMIT) || (count_inc == '0)) begin
            mode_in  = ~mode_ff;
            count_in = '0;
         end else begin
            count_in = count_inc;
         end
      end

      rsp_in.speed_command = mode_in ? cfg.fast_speed : cfg.normal_speed;
      rsp_in.fast_mode     = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data             = rsp_ff;
   assign status.mode_fast     = mode_ff;
   assign status.confirm_count = count_ff;

endmodule

// ===== design/speed_mode_hysteresis_select_unit.sv =====
// Top level of the speed mode hysteresis select unit.
//
// One sample per control tick enters on the req_ channel (req_valid, req_stall,
// req_data) and one result per sample leaves on the rsp_ channel (rsp_valid,
// rsp_stall, rsp_data). A transfer happens at a rising edge with valid high
// and stall low.
// A taken sample passes the input register, the product register and the
// result register before its result shows on rsp_.
// Throughput: one sample per cycle while rsp_stall is low; the mode and counter
// update with the result register, so the next sample sees them at once.
// When rsp_stall holds, the three registers fill and then req_stall rises;
// the waiting result stays unchanged until its transfer.
// Reset (synchronous, active high) empties the pipeline, sets normal mode,
// clears the confirmation counter and loads the register defaults.
// csr_ writes take effect on the next edge; write only while no sample is
// in flight.
module speed_mode_hysteresis_select_unit #(
   parameter int CONFIRM_COUNT = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  smhs_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output smhs_pkg::rsp_type                 rsp_data,
   input  logic                              csr_write_en,
   input  logic [smhs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [smhs_pkg::CSR_DATA_W-1:0]   csr_data
);

   smhs_pkg::csr_type     cfg;
   smhs_pkg::metric_type  metric;
   smhs_pkg::status_type  status;
   smhs_pkg::req_type     sample_ff;
   smhs_pkg::req_type     sample_in;

   logic s1_valid_ff;
   logic s1_valid_in;
   logic s2_valid_ff;
   logic s2_valid_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;

   logic accept;
   logic adv2;
   logic adv3;
   logic ready2;
   logic ready3;

   always_comb begin
      ready3    = !rsp_valid_ff || !rsp_stall;
      adv3      = s2_valid_ff && ready3;
      ready2    = !s2_valid_ff || ready3;
      adv2      = s1_valid_ff && ready2;
      req_stall = s1_valid_ff && !ready2;
      accept    = req_valid && !req_stall;

      s1_valid_in  = accept ? 1'b1 : (adv2 ? 1'b0 : s1_valid_ff);
      s2_valid_in  = adv2 ? 1'b1 : (adv3 ? 1'b0 : s2_valid_ff);
      rsp_valid_in = adv3 ? 1'b1 : (!rsp_stall ? 1'b0 : rsp_valid_ff);
      sample_in    = accept ? req_data : sample_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
   end

   smhs_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cfg          (cfg)
   );

   smhs_measure u_measure (
      .clock  (clock),
      .load   (adv2),
      .sample (sample_ff),
      .cfg    (cfg),
      .metric (metric)
   );

   smhs_decide #(
      .CONFIRM_COUNT (CONFIRM_COUNT)
   ) u_decide (
      .clock    (clock),
      .reset    (reset),
      .advance  (adv3),
      .metric   (metric),
      .cfg      (cfg),
      .rsp_data (rsp_data),
      .status   (status)
   );

   assign rsp_valid = rsp_valid_ff;

   localparam logic [smhs_pkg::COUNT_W-1:0] CONFIRM_LIMIT =
      smhs_pkg::COUNT_W'(CONFIRM_COUNT);

   a_count_below_limit: assert property (@(posedge clock) disable iff (reset)
      status.confirm_count < CONFIRM_LIMIT)
      else $error("confirmation counter reached its limit without a mode change");

   a_result_matches_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.fast_mode == status.mode_fast))
      else $error("pending result disagrees with the held mode");

   a_mode_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      !adv3 |=> $stable(status.mode_fast))
      else $error("mode changed without a sample leaving the product stage");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && rsp_valid_ff))
      else $error("input stalled while the pipeline has room");

endmodule
